@@ sv/tfa_pkg.sv @@
package tfa_pkg;

  // operation codes
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_MAC = 3'd3;
  localparam logic [2:0] KIND_DIV = 3'd4;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  localparam int MUL_BIAS     = 126;
  localparam int DIV_BIAS     = 121;
  localparam int DIV_PRESHIFT = 29;
  localparam int MAX_ALIGN    = 31;
  localparam int EXP_MAX      = 255;
  localparam int NORM_POS     = 24;   // leading one lands at bit 23

  localparam int DIV_STEPS = DIV_PRESHIFT + 1;          // quotient bits
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int EXP_W     = 12;                        // signed working exponent
  localparam int SUM_W     = 32;                        // signed working mantissa
  localparam int SHIFT_W   = $clog2(MAX_ALIGN + 1);
  localparam int LEN_W     = $clog2(SUM_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        early;      // result known up front
    logic [31:0] early_val;
  } item_t;

  function automatic logic [23:0] umant(input logic [31:0] v);
    return {1'b1, v[22:0]};
  endfunction

  function automatic logic signed [24:0] smant(input logic [31:0] v);
    logic signed [24:0] m;
    m = signed'({1'b0, umant(v)});
    if (v[30:23] == 8'd0) return '0;
    return v[31] ? -m : m;
  endfunction

  function automatic logic signed [EXP_W-1:0] exp_of(input logic [31:0] v);
    return signed'(EXP_W'(v[30:23]));
  endfunction

endpackage

@@ sv/tfa_front.sv @@
// Classifies an incoming beat: flags items whose result is settled without arithmetic.
module tfa_front (
  input  logic [2:0]     kind_i,
  input  logic [31:0]    operand_a_i,
  input  logic [31:0]    operand_b_i,
  input  logic [31:0]    operand_c_i,
  output tfa_pkg::item_t item_o
);

  logic signed [tfa_pkg::EXP_W-1:0] ae, be, ce, re_p, lim;

  always_comb begin
    ae   = tfa_pkg::exp_of(operand_a_i);
    be   = tfa_pkg::exp_of(operand_b_i);
    ce   = tfa_pkg::exp_of(operand_c_i);
    re_p = ae + be - tfa_pkg::EXP_W'(tfa_pkg::MUL_BIAS);
    lim  = tfa_pkg::EXP_W'(tfa_pkg::MAX_ALIGN);

    item_o.kind      = kind_i;
    item_o.a         = operand_a_i;
    item_o.b         = operand_b_i;
    item_o.c         = operand_c_i;
    item_o.early     = 1'b0;
    item_o.early_val = '0;

    case (kind_i)
      tfa_pkg::KIND_ADD, tfa_pkg::KIND_SUB: begin
        if (ae > be) begin
          if ((ae - be) > lim) begin
            item_o.early     = 1'b1;
            item_o.early_val = operand_a_i;
          end
        end else if ((be - ae) > lim) begin
          item_o.early     = 1'b1;
          item_o.early_val = (kind_i == tfa_pkg::KIND_SUB) ?
                             (operand_b_i ^ tfa_pkg::SIGN_BIT) : operand_b_i;
        end
      end
      tfa_pkg::KIND_MUL: begin
        if (ae == '0 || be == '0) item_o.early = 1'b1;
      end
      tfa_pkg::KIND_MAC: begin
        if (ae == '0 || be == '0 || (ce > re_p && (ce - re_p) > lim)) begin
          item_o.early     = 1'b1;
          item_o.early_val = operand_c_i;
        end
      end
      tfa_pkg::KIND_DIV: begin
        if (operand_a_i[30:0] == 31'd0 || operand_b_i[30:0] == 31'd0) item_o.early = 1'b1;
      end
      default: begin
        item_o.early = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/tfa_queue.sv @@
// Short FIFO between the front and the back.
module tfa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfa_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tfa_pkg::item_t item_o
);

  tfa_pkg::item_t                mem_q [tfa_pkg::QUEUE_DEPTH];
  logic [tfa_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tfa_pkg::QPTR_W:0]      count_q, count_d;

  assign full_o  = (count_q == (tfa_pkg::QPTR_W+1)'(tfa_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

@@ sv/tfa_back.sv @@
// Execution pipeline: multiply/divide, align, add, leading-one count, normalize and pack.
module tfa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  tfa_pkg::item_t item_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [31:0]    result_o,
  output logic           flag_o
);

  localparam int EW = tfa_pkg::EXP_W;
  localparam int SW = tfa_pkg::SUM_W;

  // ---- stage valids and flow control
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic s1_done, s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

  // ---- s1: divider and partial products
  tfa_pkg::item_t                   s1_item_q;
  logic [tfa_pkg::CNT_W-1:0]        cnt_q;
  logic [23:0]                      rem_q, rem_d;
  logic [tfa_pkg::DIV_STEPS-1:0]    quot_q, quot_d;
  logic [24:0]                      div_t, den;
  logic                             div_ge, div_bit;
  logic [11:0]                      ah, al, bh, bl;
  logic [23:0]                      pp_hh;
  logic [24:0]                      pp_x;

  // ---- s2
  tfa_pkg::item_t                   s2_item_q;
  logic [23:0]                      s2_hh_q;
  logic [24:0]                      s2_x_q;
  logic [tfa_pkg::DIV_STEPS-1:0]    s2_quot_q;

  logic [23:0]                      prod;
  logic                             psign;
  logic signed [SW-1:0]             spr, am, bm, cm;
  logic signed [EW-1:0]             ae, be, ce, re_p, dd;
  logic signed [SW-1:0]             al_x, al_y;
  logic [tfa_pkg::SHIFT_W-1:0]      al_s;
  logic                             al_neg, al_esign;
  logic signed [EW-1:0]             al_re;

  // ---- s3
  logic signed [SW-1:0]             s3_x_q, s3_y_q;
  logic [tfa_pkg::SHIFT_W-1:0]      s3_s_q;
  logic                             s3_neg_q, s3_esign_q, s3_early_q;
  logic signed [EW-1:0]             s3_re_q;
  logic [31:0]                      s3_eval_q;
  logic signed [SW-1:0]             sh, sum;

  // ---- s4
  logic signed [SW-1:0]             s4_sum_q;
  logic signed [EW-1:0]             s4_re_q;
  logic                             s4_esign_q, s4_early_q;
  logic [31:0]                      s4_eval_q;
  logic [SW-1:0]                    mag;
  logic [tfa_pkg::LEN_W-1:0]        len;

  // ---- s5
  logic signed [SW-1:0]             s5_sum_q;
  logic [tfa_pkg::LEN_W-1:0]        s5_len_q;
  logic signed [EW-1:0]             s5_re_q;
  logic                             s5_esign_q, s5_early_q;
  logic [31:0]                      s5_eval_q;
  logic signed [SW-1:0]             rn;
  logic [SW-1:0]                    rmag;
  logic signed [EW-1:0]             re_n;
  logic [31:0]                      res;
  logic                             flg;

  // ---- output register
  logic [31:0] out_res_q;
  logic        out_flag_q;

  assign out_rdy = !out_v_q || !stall_i;
  assign s5_rdy  = !s5_v_q || out_rdy;
  assign s4_rdy  = !s4_v_q || s5_rdy;
  assign s3_rdy  = !s3_v_q || s4_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_done = s1_v_q && (cnt_q == tfa_pkg::CNT_W'(tfa_pkg::DIV_STEPS));
  assign s1_rdy  = !s1_v_q || (s1_done && s2_rdy);
  assign pop_o   = in_valid_i && s1_rdy;

  assign valid_o  = out_v_q;
  assign result_o = out_res_q;
  assign flag_o   = out_flag_q;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    div_bit = (cnt_q == '0) ? s1_item_q.a[0] : 1'b0;
    den     = {1'b0, tfa_pkg::umant(s1_item_q.b)};
    div_t   = {rem_q, div_bit};
    div_ge  = (div_t >= den);
    rem_d   = div_ge ? 24'(div_t - den) : div_t[23:0];
    quot_d  = {quot_q[tfa_pkg::DIV_STEPS-2:0], div_ge};
    ah      = {1'b1, s1_item_q.a[22:12]};
    al      = s1_item_q.a[11:0];
    bh      = {1'b1, s1_item_q.b[22:12]};
    bl      = s1_item_q.b[11:0];
    pp_hh   = ah * bh;
    pp_x    = 25'(ah * bl) + 25'(bh * al);
  end

  // product, signs and operand alignment
  always_comb begin
    prod     = s2_hh_q + 24'(s2_x_q >> 12);
    psign    = s2_item_q.a[31] ^ s2_item_q.b[31];
    spr      = psign ? -SW'(signed'({1'b0, prod})) : SW'(signed'({1'b0, prod}));
    am       = SW'(tfa_pkg::smant(s2_item_q.a));
    bm       = SW'(tfa_pkg::smant(s2_item_q.b));
    cm       = SW'(tfa_pkg::smant(s2_item_q.c));
    ae       = tfa_pkg::exp_of(s2_item_q.a);
    be       = tfa_pkg::exp_of(s2_item_q.b);
    ce       = tfa_pkg::exp_of(s2_item_q.c);
    re_p     = ae + be - EW'(tfa_pkg::MUL_BIAS);
    dd       = re_p - ce;
    al_x     = '0;
    al_y     = '0;
    al_s     = '0;
    al_neg   = 1'b0;
    al_esign = 1'b0;
    al_re    = '0;
    case (s2_item_q.kind)
      tfa_pkg::KIND_ADD, tfa_pkg::KIND_SUB: begin
        if (ae > be) begin
          al_s   = tfa_pkg::SHIFT_W'(ae - be);
          al_x   = am;
          al_y   = bm;
          al_neg = (s2_item_q.kind == tfa_pkg::KIND_SUB);
          al_re  = ae;
        end else begin
          al_s  = tfa_pkg::SHIFT_W'(be - ae);
          al_x  = (s2_item_q.kind == tfa_pkg::KIND_SUB) ? -bm : bm;
          al_y  = am;
          al_re = be;
        end
      end
      tfa_pkg::KIND_MUL: begin
        al_x  = spr;
        al_re = re_p;
      end
      tfa_pkg::KIND_MAC: begin
        if (ce > re_p) begin
          al_s  = tfa_pkg::SHIFT_W'(ce - re_p);
          al_x  = cm;
          al_y  = spr;
          al_re = ce;
        end else begin
          al_x  = spr;
          al_re = re_p;
          if (dd <= EW'(tfa_pkg::MAX_ALIGN)) begin
            al_y = cm;
            al_s = tfa_pkg::SHIFT_W'(dd);
          end
        end
      end
      tfa_pkg::KIND_DIV: begin
        al_x     = SW'(signed'({1'b0, s2_quot_q}));
        al_re    = ae - be + EW'(tfa_pkg::DIV_BIAS);
        al_esign = psign;
      end
      default: begin
        al_x = '0;
      end
    endcase
  end

  // aligned add; arithmetic shift floors
  always_comb begin
    sh  = s3_y_q >>> s3_s_q;
    sum = s3_neg_q ? s3_x_q - sh : s3_x_q + sh;
  end

  // leading-one position
  always_comb begin
    mag = s4_sum_q[SW-1] ? SW'(-s4_sum_q) : SW'(s4_sum_q);
    len = '0;
    for (int i = 0; i < SW; i++) begin
      if (mag[i]) len = tfa_pkg::LEN_W'(i + 1);
    end
  end

  // normalize and pack
  always_comb begin
    if (s5_len_q < tfa_pkg::LEN_W'(tfa_pkg::NORM_POS)) begin
      rn = s5_sum_q <<< (tfa_pkg::LEN_W'(tfa_pkg::NORM_POS) - s5_len_q);
    end else begin
      rn = s5_sum_q >>> (s5_len_q - tfa_pkg::LEN_W'(tfa_pkg::NORM_POS));
    end
    re_n = s5_re_q + signed'(EW'(s5_len_q)) - EW'(tfa_pkg::NORM_POS);
    rmag = rn[SW-1] ? SW'(-rn) : SW'(rn);
    res  = {rn[SW-1] | s5_esign_q, 8'd0, rmag[22:0]} | {re_n[8:0], 23'd0};
    flg  = (re_n < 0) || (re_n > EW'(tfa_pkg::EXP_MAX));
    if (s5_early_q) begin
      res = s5_eval_q;
      flg = 1'b0;
    end else if (s5_sum_q == '0) begin
      res = '0;
      flg = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_valid_i;
      if (s2_rdy)  s2_v_q  <= s1_done;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (s4_rdy)  s4_v_q  <= s3_v_q;
      if (s5_rdy)  s5_v_q  <= s4_v_q;
      if (out_rdy) out_v_q <= s5_v_q;
      if (pop_o) begin
        cnt_q <= (item_i.kind == tfa_pkg::KIND_DIV && !item_i.early) ?
                 '0 : tfa_pkg::CNT_W'(tfa_pkg::DIV_STEPS);
      end else if (s1_v_q && !s1_done) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_item_q <= item_i;
      rem_q     <= {1'b0, 1'b1, item_i.a[22:1]};
      quot_q    <= '0;
    end else if (s1_v_q && !s1_done) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
    if (s2_rdy && s1_done) begin
      s2_item_q <= s1_item_q;
      s2_hh_q   <= pp_hh;
      s2_x_q    <= pp_x;
      s2_quot_q <= quot_q;
    end
    if (s3_rdy && s2_v_q) begin
      s3_x_q     <= al_x;
      s3_y_q     <= al_y;
      s3_s_q     <= al_s;
      s3_neg_q   <= al_neg;
      s3_esign_q <= al_esign;
      s3_re_q    <= al_re;
      s3_early_q <= s2_item_q.early;
      s3_eval_q  <= s2_item_q.early_val;
    end
    if (s4_rdy && s3_v_q) begin
      s4_sum_q   <= sum;
      s4_re_q    <= s3_re_q;
      s4_esign_q <= s3_esign_q;
      s4_early_q <= s3_early_q;
      s4_eval_q  <= s3_eval_q;
    end
    if (s5_rdy && s4_v_q) begin
      s5_sum_q   <= s4_sum_q;
      s5_len_q   <= len;
      s5_re_q    <= s4_re_q;
      s5_esign_q <= s4_esign_q;
      s5_early_q <= s4_early_q;
      s5_eval_q  <= s4_eval_q;
    end
    if (out_rdy && s5_v_q) begin
      out_res_q  <= res;
      out_flag_q <= flg;
    end
  end

endmodule

@@ sv/truncating_float_alu_unit.sv @@
// Truncating single-precision ALU: add, subtract, multiply, c + a*b, divide.
// Input channel: valid_i / stall_o with kind_i and operand_a_i.._c_i; a beat
//   is taken on a rising edge with valid_i high and stall_o low.
// Output channel: valid_o / stall_i with result_o and exponent_out_of_range_o.
// Throughput: one beat per cycle for add, subtract, multiply and c + a*b
//   while nothing stalls. A divide not settled up front holds the first
//   execute stage while the restoring divider produces one quotient bit
//   per cycle; beats behind it wait in the queue, beats ahead keep draining.
// Path from input beat to output valid: queue, divide/partial products,
//   align, add, leading-one count, normalize/pack into the output register.
// The front classifies each beat (early results: far alignment, zero
//   operands, unknown kinds) and writes it into a 4-entry queue; stall_o is
//   the queue-full flag. Results leave in input order.
// A stall on the output holds the result register; the pipeline fills up
//   behind it, then the queue, and only then stall_o rises.
// Reset clears all valids and the queue; beats are taken right after reset.
module truncating_float_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [31:0] operand_c_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] result_o,
  output logic        exponent_out_of_range_o
);

  tfa_pkg::item_t front_item, head_item;
  logic           q_full, q_valid, q_pop, q_push;

  assign q_push  = valid_i && !q_full;
  assign stall_o = q_full;

  tfa_front u_front (
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .operand_c_i (operand_c_i),
    .item_o      (front_item)
  );

  tfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tfa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .item_i     (head_item),
    .pop_o      (q_pop),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .result_o   (result_o),
    .flag_o     (exponent_out_of_range_o)
  );

endmodule

@@ sv/tfa_checker.sv @@
module tfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic [2:0]  kind_i,
  input logic [31:0] operand_a_i,
  input logic [31:0] operand_b_i,
  input logic [31:0] operand_c_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] result_o,
  input logic        exponent_out_of_range_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(result_o) && $stable(exponent_out_of_range_o))
    else $error("output payload changed under stall");

  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("output valid right after reset");

  a_reset_queue: assert property (@(posedge clk_i)
    !rst_ni |=> !stall_o)
    else $error("queue not empty right after reset");

endmodule

bind truncating_float_alu_unit tfa_checker u_tfa_checker (.*);
